// ===== hw/rtl/vrst_pkg.sv =====
// Shared types, widths and codes of the voxel ray segment tracer.
`default_nettype none
package vrst_pkg;

	localparam int BINS_DEF  = 16;
	localparam int COORD_W   = 24;
	localparam int BIN_W     = 16;
	localparam int IDX_W     = 4;
	localparam int CHORD_W   = 25;
	localparam int CFG_IDX_W = 3;
	localparam int IN_W      = 6 * COORD_W;
	localparam int OUT_W     = 40;
	localparam int DIV_W     = 24;
	localparam int QUOT_W    = 32;
	localparam int DIV_STEP  = 4;
	localparam int SQ_W      = 50;
	localparam int LEN_W     = 25;
	localparam int MUL_W     = 25;
	localparam int POS_W     = 26;
	localparam int T_W       = 33;
	localparam int MAX_RES   = 46;
	localparam int CNT_W     = 6;

	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BIN_X    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BIN_Y    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BIN_Z    = 3'd5;

	localparam logic [1:0] AX_X = 2'd0;
	localparam logic [1:0] AX_Z = 2'd2;
	localparam logic [2:0] JOB_FIRST = 3'd0;
	localparam logic [2:0] JOB_LAST  = 3'd5;

	typedef enum logic [4:0] {
		ST_IDLE, ST_SETUP, ST_SQ_MUL, ST_SQ_ADD, ST_DIV_LOAD, ST_DIV_WAIT, ST_INIT,
		ST_NUM, ST_CMP_MUL, ST_CMP_UPD, ST_PICK, ST_T_LOAD, ST_T_WAIT, ST_T_FIX,
		ST_CH_MUL, ST_CH_SUM, ST_EMIT, ST_ADV, ST_FLUSH
	} vrst_state_t;

	typedef struct packed {
		logic       load;
		logic       setup;
		logic       sq_mul;
		logic       sq_add;
		logic       sqrt_start;
		logic       div_bin;
		logic       div_t;
		logic       div_store;
		logic       init;
		logic       num;
		logic       cmp_mul;
		logic       cmp_upd;
		logic       set_final;
		logic       t_fix;
		logic       ch_mul;
		logic       ch_sum;
		logic       push;
		logic       adv;
		logic       flush;
		logic [1:0] ax;
		logic [2:0] job;
	} vrst_cmd_t;

	typedef struct packed {
		logic sqrt_busy;
		logic div_busy;
		logic div_done;
		logic best_valid;
		logic emit_ok;
		logic pend_valid;
		logic out_free;
	} vrst_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/vrst_div.sv =====
// Unsigned restoring divider, four quotient bits per cycle.
`default_nettype none
module vrst_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [vrst_pkg::DIV_W-1:0]  rem_init,
	input  wire logic [vrst_pkg::QUOT_W-1:0] dividend,
	input  wire logic [vrst_pkg::DIV_W-1:0]  divisor,
	output logic      [vrst_pkg::QUOT_W-1:0] quot,
	output logic      [vrst_pkg::DIV_W-1:0]  rem,
	output logic                            busy,
	output logic                            done
);
	import vrst_pkg::*;

	localparam int ITER = QUOT_W / DIV_STEP;
	localparam int CW = $clog2(ITER);
	localparam logic [CW-1:0] CNT_END = CW'(ITER - 1);

	logic [DIV_W-1:0]  rem_q, div_q, rem_n;
	logic [QUOT_W-1:0] sh_q, quot_q, sh_n, quot_n;
	logic [CW-1:0]     cnt_q;
	logic              busy_q, done_q;

	always_comb begin
		logic [DIV_W:0] tmp;
		rem_n = rem_q;
		sh_n = sh_q;
		quot_n = quot_q;
		tmp = '0;
		for (int k = 0; k < DIV_STEP; k++) begin
			tmp = {rem_n, sh_n[QUOT_W-1]};
			sh_n = {sh_n[QUOT_W-2:0], 1'b0};
			if (tmp >= {1'b0, div_q}) begin
				tmp = tmp - {1'b0, div_q};
				quot_n = {quot_n[QUOT_W-2:0], 1'b1};
			end else begin
				quot_n = {quot_n[QUOT_W-2:0], 1'b0};
			end
			rem_n = tmp[DIV_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_END) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			sh_q <= dividend;
			div_q <= divisor;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q <= rem_n;
			sh_q <= sh_n;
			quot_q <= quot_n;
		end
	end

	assign quot = quot_q;
	assign rem = rem_q;
	assign busy = busy_q;
	assign done = done_q;

endmodule
`default_nettype wire

// ===== hw/rtl/vrst_sqrt.sv =====
// Bit-serial integer square root, one result bit per cycle.
`default_nettype none
module vrst_sqrt (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [vrst_pkg::SQ_W-1:0]  radicand,
	output logic      [vrst_pkg::LEN_W-1:0] root,
	output logic                           busy
);
	import vrst_pkg::*;

	localparam int ITER = SQ_W / 2;
	localparam int CW = $clog2(ITER);
	localparam logic [CW-1:0] CNT_END = CW'(ITER - 1);

	logic [SQ_W-1:0]  sh_q;
	logic [LEN_W+1:0] rem_q, rem_n;
	logic [LEN_W-1:0] root_q, root_n;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;

	always_comb begin
		logic [LEN_W+3:0] cur, trial;
		cur = {rem_q, sh_q[SQ_W-1 -: 2]};
		trial = {2'b00, root_q, 2'b01};
		if (cur >= trial) begin
			rem_n = (LEN_W+2)'(cur - trial);
			root_n = {root_q[LEN_W-2:0], 1'b1};
		end else begin
			rem_n = cur[LEN_W+1:0];
			root_n = {root_q[LEN_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_END)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q <= radicand;
			rem_q <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			sh_q <= {sh_q[SQ_W-3:0], 2'b00};
			rem_q <= rem_n;
			root_q <= root_n;
		end
	end

	assign root = root_q;
	assign busy = busy_q;

endmodule
`default_nettype wire

// ===== hw/rtl/vrst_dp.sv =====
// Tracer datapath: registers, setup arithmetic, crossing compare, chord and result buffers.
`default_nettype none
module vrst_dp #(
	parameter int BINS_X = vrst_pkg::BINS_DEF,
	parameter int BINS_Y = vrst_pkg::BINS_DEF,
	parameter int BINS_Z = vrst_pkg::BINS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [vrst_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [vrst_pkg::COORD_W-1:0]   cfg_data,
	input  wire logic [vrst_pkg::IN_W-1:0]      in_data,
	input  wire vrst_pkg::vrst_cmd_t            cmd,
	output vrst_pkg::vrst_stat_t                stat,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [vrst_pkg::OUT_W-1:0]          out_data,
	output logic                               out_inside,
	output logic                               out_last
);
	import vrst_pkg::*;

	localparam logic [4:0] NB_X = 5'(BINS_X);
	localparam logic [4:0] NB_Y = 5'(BINS_Y);
	localparam logic [4:0] NB_Z = 5'(BINS_Z);
	localparam logic [T_W-1:0] T_ONE = {1'b1, {(T_W-1){1'b0}}};
	localparam logic [CHORD_W-1:0] CHORD_MAX = '1;

	logic signed [COORD_W-1:0] org_q [3];
	logic [BIN_W-1:0]          bin_q [3];
	logic [BIN_W-1:0]          binv [3];
	logic [4:0]                nb [3];
	logic signed [COORD_W-1:0] s_q [3], e_q [3];
	logic [DIV_W-1:0]          ad_q [3], an_q [3];
	logic                      dpos_q [3], dneg_q [3], act_q [3];
	logic signed [COORD_W:0]   off_q [3];
	logic signed [POS_W-1:0]   from_q [3], to_q [3], idx_q [3];
	logic [4:0]                bnext_q [3], bstop_q [3];
	logic [SQ_W-1:0]           sum_q;
	logic [2*MUL_W-1:0]        prod_a_q, prod_b_q;
	logic [MUL_W-1:0]          mul_a0, mul_a1, mul_b0, mul_b1;
	logic                      neg_q;
	logic [1:0]                best_q;
	logic                      best_valid_q;
	logic [DIV_W-1:0]          an_best_q, ad_best_q;
	logic [T_W-1:0]            t_q, told_q, dt;
	logic [CHORD_W-1:0]        chord_q;
	logic [CNT_W-1:0]          count_q;
	logic                      pend_valid_q;
	logic [IDX_W-1:0]          pend_x_q, pend_y_q, pend_z_q;
	logic [CHORD_W-1:0]        pend_chord_q;
	logic                      out_valid_q, out_inside_q, out_last_q;
	logic [IDX_W-1:0]          out_x_q, out_y_q, out_z_q;
	logic [CHORD_W-1:0]        out_chord_q;
	logic                      in_grid, out_free;
	logic [1:0]                div_ax;
	logic [DIV_W-1:0]          div_mag;
	logic                      div_neg;
	logic [QUOT_W-1:0]         quot;
	logic [DIV_W-1:0]          drem;
	logic                      div_busy, div_done, sqrt_busy;
	logic [LEN_W-1:0]          len;
	logic [SQ_W-1:0]           sum_n;
	logic signed [POS_W-1:0]   floor_q;

	assign nb[0] = NB_X;
	assign nb[1] = NB_Y;
	assign nb[2] = NB_Z;

	always_comb begin
		for (int a = 0; a < 3; a++)
			binv[a] = (bin_q[a] == '0) ? BIN_W'(1) : bin_q[a];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) begin
				org_q[a] <= '0;
				bin_q[a] <= BIN_W'(256);
			end
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ORIGIN_X: org_q[0] <= cfg_data;
				REG_ORIGIN_Y: org_q[1] <= cfg_data;
				REG_ORIGIN_Z: org_q[2] <= cfg_data;
				REG_BIN_X:    bin_q[0] <= cfg_data[BIN_W-1:0];
				REG_BIN_Y:    bin_q[1] <= cfg_data[BIN_W-1:0];
				REG_BIN_Z:    bin_q[2] <= cfg_data[BIN_W-1:0];
				default: ;
			endcase
		end
	end

	// floor division operands: one end point of one axis per job
	assign div_ax = cmd.job[2:1];
	always_comb begin
		logic signed [COORD_W-1:0] p;
		logic signed [COORD_W:0]   diff;
		p = cmd.job[0] ? e_q[div_ax] : s_q[div_ax];
		diff = {p[COORD_W-1], p} - {org_q[div_ax][COORD_W-1], org_q[div_ax]};
		div_neg = diff[COORD_W];
		div_mag = DIV_W'(diff[COORD_W] ? -diff : diff);
	end

	vrst_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_bin | cmd.div_t),
		.rem_init (cmd.div_t ? an_best_q : '0),
		.dividend (cmd.div_t ? '0 : QUOT_W'(div_mag)),
		.divisor  (cmd.div_t ? ad_best_q : DIV_W'(binv[div_ax])),
		.quot     (quot),
		.rem      (drem),
		.busy     (div_busy),
		.done     (div_done)
	);

	assign sum_n = sum_q + SQ_W'(prod_a_q);

	vrst_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.sqrt_start),
		.radicand (sum_n),
		.root     (len),
		.busy     (sqrt_busy)
	);

	always_comb begin
		logic signed [POS_W-1:0] qv;
		qv = POS_W'(quot[COORD_W:0]);
		floor_q = neg_q ? -(qv + POS_W'(drem != '0)) : qv;
	end

	// multiplier operands
	assign dt = t_q - told_q;
	always_comb begin
		mul_a0 = '0;
		mul_a1 = '0;
		mul_b0 = '0;
		mul_b1 = '0;
		if (cmd.sq_mul) begin
			mul_a0 = MUL_W'(ad_q[cmd.ax]);
			mul_a1 = MUL_W'(ad_q[cmd.ax]);
		end else if (cmd.cmp_mul) begin
			mul_a0 = MUL_W'(an_q[cmd.ax]);
			mul_a1 = MUL_W'(ad_best_q);
			mul_b0 = MUL_W'(an_best_q);
			mul_b1 = MUL_W'(ad_q[cmd.ax]);
		end else begin
			mul_a0 = MUL_W'(dt[15:0]);
			mul_a1 = MUL_W'(len);
			mul_b0 = MUL_W'(dt[T_W-1:16]);
			mul_b1 = MUL_W'(len);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sq_mul || cmd.cmp_mul || cmd.ch_mul) begin
			prod_a_q <= mul_a0 * mul_a1;
			prod_b_q <= mul_b0 * mul_b1;
		end
	end

	always_comb begin
		in_grid = 1'b1;
		for (int a = 0; a < 3; a++)
			if (idx_q[a] < 0 || idx_q[a] >= $signed(POS_W'(nb[a])))
				in_grid = 1'b0;
	end

	assign out_free = !out_valid_q || out_ready;

	// segment state
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int a = 0; a < 3; a++) begin
				s_q[a] <= in_data[a*COORD_W +: COORD_W];
				e_q[a] <= in_data[(a+3)*COORD_W +: COORD_W];
			end
		end
		if (cmd.setup) begin
			for (int a = 0; a < 3; a++) begin
				logic signed [COORD_W:0] d;
				d = {e_q[a][COORD_W-1], e_q[a]} - {s_q[a][COORD_W-1], s_q[a]};
				ad_q[a] <= DIV_W'(d[COORD_W] ? -d : d);
				dneg_q[a] <= d[COORD_W];
				dpos_q[a] <= !d[COORD_W] && (d != '0);
				off_q[a] <= {org_q[a][COORD_W-1], org_q[a]} - {s_q[a][COORD_W-1], s_q[a]};
			end
			sum_q <= '0;
		end
		if (cmd.sq_add)
			sum_q <= sum_n;
		if (cmd.div_bin)
			neg_q <= div_neg;
		if (cmd.div_store) begin
			if (cmd.job[0])
				to_q[div_ax] <= floor_q;
			else
				from_q[div_ax] <= floor_q;
		end
		if (cmd.init) begin
			for (int a = 0; a < 3; a++) begin
				logic signed [POS_W-1:0] n, lo, hi, fp1, tp1;
				n = POS_W'(nb[a]);
				fp1 = from_q[a] + POS_W'(1);
				tp1 = to_q[a] + POS_W'(1);
				lo = '0;
				hi = '0;
				if (dpos_q[a]) begin
					lo = (fp1 < 0) ? '0 : fp1;
					hi = (to_q[a] < n) ? to_q[a] : n;
					bnext_q[a] <= lo[4:0];
					bstop_q[a] <= hi[4:0];
				end else begin
					hi = (from_q[a] < n) ? from_q[a] : n;
					lo = (tp1 < 0) ? '0 : tp1;
					bnext_q[a] <= hi[4:0];
					bstop_q[a] <= lo[4:0];
				end
				act_q[a] <= (dpos_q[a] || dneg_q[a]) && (lo <= hi);
				idx_q[a] <= from_q[a];
			end
			told_q <= '0;
		end
		if (cmd.num) begin
			for (int a = 0; a < 3; a++) begin
				logic signed [COORD_W+2:0] num;
				logic [COORD_W+2:0] mag;
				num = {{2{off_q[a][COORD_W]}}, off_q[a]}
					+ $signed({6'b0, 21'(bnext_q[a]) * 21'(binv[a])});
				mag = num[COORD_W+2] ? -num : num;
				an_q[a] <= (mag > (COORD_W+3)'(ad_q[a])) ? ad_q[a] : DIV_W'(mag);
			end
		end
		if (cmd.cmp_upd && act_q[cmd.ax] && (!best_valid_q || prod_a_q < prod_b_q)) begin
			best_q <= cmd.ax;
			an_best_q <= an_q[cmd.ax];
			ad_best_q <= ad_q[cmd.ax];
		end
		if (cmd.set_final)
			t_q <= T_ONE;
		if (cmd.t_fix) begin
			logic [T_W-1:0] tv;
			tv = (an_best_q == ad_best_q) ? T_ONE : {1'b0, quot};
			t_q <= (tv < told_q) ? told_q : tv;
		end
		if (cmd.ch_sum) begin
			logic [58:0] acc;
			logic [26:0] cf;
			acc = 59'(prod_a_q) + (59'(prod_b_q) << 16) + (59'(1) << 31);
			cf = acc[58:32];
			chord_q <= (cf > 27'(CHORD_MAX)) ? CHORD_MAX : cf[CHORD_W-1:0];
		end
		if (cmd.push) begin
			pend_x_q <= idx_q[0][IDX_W-1:0];
			pend_y_q <= idx_q[1][IDX_W-1:0];
			pend_z_q <= idx_q[2][IDX_W-1:0];
			pend_chord_q <= chord_q;
		end
		if (cmd.adv) begin
			told_q <= t_q;
			for (int a = 0; a < 3; a++) begin
				if (best_q == 2'(a)) begin
					idx_q[a] <= dpos_q[a] ? POS_W'(bnext_q[a]) : POS_W'(bnext_q[a]) - POS_W'(1);
					if (bnext_q[a] == bstop_q[a])
						act_q[a] <= 1'b0;
					else if (dpos_q[a])
						bnext_q[a] <= bnext_q[a] + 5'd1;
					else
						bnext_q[a] <= bnext_q[a] - 5'd1;
				end
			end
		end
	end

	// control flags and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_valid_q <= 1'b0;
			count_q <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.num)
				best_valid_q <= 1'b0;
			else if (cmd.cmp_upd && act_q[cmd.ax])
				best_valid_q <= 1'b1;
			if (cmd.init) begin
				count_q <= '0;
				pend_valid_q <= 1'b0;
			end
			if (cmd.flush || (cmd.push && pend_valid_q))
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (cmd.push) begin
				count_q <= count_q + 1'b1;
				pend_valid_q <= 1'b1;
			end
			if (cmd.flush)
				pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push && pend_valid_q) begin
			out_x_q <= pend_x_q;
			out_y_q <= pend_y_q;
			out_z_q <= pend_z_q;
			out_chord_q <= pend_chord_q;
			out_inside_q <= 1'b1;
			out_last_q <= 1'b0;
		end
		if (cmd.flush) begin
			out_x_q <= pend_valid_q ? pend_x_q : '0;
			out_y_q <= pend_valid_q ? pend_y_q : '0;
			out_z_q <= pend_valid_q ? pend_z_q : '0;
			out_chord_q <= pend_valid_q ? pend_chord_q : '0;
			out_inside_q <= pend_valid_q;
			out_last_q <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = {3'b000, out_chord_q, out_z_q, out_y_q, out_x_q};
	assign out_inside = out_inside_q;
	assign out_last = out_last_q;

	assign stat.sqrt_busy = sqrt_busy;
	assign stat.div_busy = div_busy;
	assign stat.div_done = div_done;
	assign stat.best_valid = best_valid_q;
	assign stat.emit_ok = in_grid && (count_q < CNT_W'(MAX_RES));
	assign stat.pend_valid = pend_valid_q;
	assign stat.out_free = out_free;

endmodule
`default_nettype wire

// ===== hw/rtl/vrst_ctrl.sv =====
// Tracer sequencer: steps setup, floor divisions, crossing walk and result flush.
`default_nettype none
module vrst_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	output vrst_pkg::vrst_cmd_t       cmd,
	input  wire vrst_pkg::vrst_stat_t stat
);
	import vrst_pkg::*;

	vrst_state_t state_q, state_d;
	logic [1:0]  ax_q;
	logic [2:0]  job_q;
	logic        final_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (in_valid) state_d = ST_SETUP;
			ST_SETUP:    state_d = ST_SQ_MUL;
			ST_SQ_MUL:   state_d = ST_SQ_ADD;
			ST_SQ_ADD:   state_d = (ax_q == AX_Z) ? ST_DIV_LOAD : ST_SQ_MUL;
			ST_DIV_LOAD: state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: if (stat.div_done) state_d = (job_q == JOB_LAST) ? ST_INIT : ST_DIV_LOAD;
			ST_INIT:     if (!stat.sqrt_busy) state_d = ST_NUM;
			ST_NUM:      state_d = ST_CMP_MUL;
			ST_CMP_MUL:  state_d = ST_CMP_UPD;
			ST_CMP_UPD:  state_d = (ax_q == AX_Z) ? ST_PICK : ST_CMP_MUL;
			ST_PICK:     state_d = stat.best_valid ? ST_T_LOAD : ST_CH_MUL;
			ST_T_LOAD:   state_d = ST_T_WAIT;
			ST_T_WAIT:   if (stat.div_done) state_d = ST_T_FIX;
			ST_T_FIX:    state_d = ST_CH_MUL;
			ST_CH_MUL:   state_d = ST_CH_SUM;
			ST_CH_SUM:   state_d = ST_EMIT;
			ST_EMIT: begin
				// a pending result can only move on when the output register frees up
				if (!(stat.emit_ok && stat.pend_valid && !stat.out_free))
					state_d = final_q ? ST_FLUSH : ST_ADV;
			end
			ST_ADV:      state_d = ST_NUM;
			ST_FLUSH:    if (stat.out_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.ax = ax_q;
		cmd.job = job_q;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_SETUP:    cmd.setup = 1'b1;
			ST_SQ_MUL:   cmd.sq_mul = 1'b1;
			ST_SQ_ADD: begin
				cmd.sq_add = 1'b1;
				cmd.sqrt_start = (ax_q == AX_Z);
			end
			ST_DIV_LOAD: cmd.div_bin = 1'b1;
			ST_DIV_WAIT: cmd.div_store = stat.div_done;
			ST_INIT:     cmd.init = !stat.sqrt_busy;
			ST_NUM:      cmd.num = 1'b1;
			ST_CMP_MUL:  cmd.cmp_mul = 1'b1;
			ST_CMP_UPD:  cmd.cmp_upd = 1'b1;
			ST_PICK:     cmd.set_final = !stat.best_valid;
			ST_T_LOAD:   cmd.div_t = 1'b1;
			ST_T_WAIT:   ;
			ST_T_FIX:    cmd.t_fix = 1'b1;
			ST_CH_MUL:   cmd.ch_mul = 1'b1;
			ST_CH_SUM:   cmd.ch_sum = 1'b1;
			ST_EMIT:     cmd.push = stat.emit_ok && (!stat.pend_valid || stat.out_free);
			ST_ADV:      cmd.adv = 1'b1;
			ST_FLUSH:    cmd.flush = stat.out_free;
			default:     ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ax_q <= AX_X;
			job_q <= JOB_FIRST;
			final_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_SETUP:   ax_q <= AX_X;
				ST_SQ_ADD: begin
					ax_q <= ax_q + 2'd1;
					job_q <= JOB_FIRST;
				end
				ST_DIV_WAIT: if (stat.div_done) job_q <= job_q + 3'd1;
				ST_INIT:    final_q <= 1'b0;
				ST_NUM:     ax_q <= AX_X;
				ST_CMP_UPD: ax_q <= ax_q + 2'd1;
				ST_PICK:    final_q <= !stat.best_valid;
				default:    ;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push && stat.pend_valid) |-> stat.out_free)
		else $error("result pushed into a full output register");
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_bin || cmd.div_t) |-> !stat.div_busy)
		else $error("divider restarted while busy");
	a_div_expected: assert property (@(posedge clk) disable iff (!arst_n)
		stat.div_done |-> (state_q == ST_DIV_WAIT || state_q == ST_T_WAIT))
		else $error("divider finished outside a wait state");
	a_flush_ends: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |=> in_ready)
		else $error("segment not closed after flush");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/voxel_ray_segment_tracer.sv =====
// Top level of the voxel ray segment tracer.
`default_nettype none
// Traces one segment at a time through a BINS_X x BINS_Y x BINS_Z voxel grid and
// streams one transfer per crossed voxel, up to 46 (indices, chord length),
// tlast on the final one; a segment that misses the grid gives a single
// transfer with tuser = 0. Setup runs six floor divisions on the shared
// divider (4 quotient bits per cycle) while the square root of the squared
// length runs alongside. Each boundary crossing then goes through the
// sequential three-axis compare on the shared multipliers and the 32-bit
// crossing-parameter division, and a closing step ends the segment. A new
// segment is taken once the previous one has been flushed into the output
// register.
module voxel_ray_segment_tracer #(
	parameter int BINS_X = vrst_pkg::BINS_DEF,
	parameter int BINS_Y = vrst_pkg::BINS_DEF,
	parameter int BINS_Z = vrst_pkg::BINS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// start_x, start_y, start_z, end_x, end_y, end_z
	input  wire logic [vrst_pkg::IN_W-1:0]      s_tdata,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// voxel_x, voxel_y, voxel_z, chord_length, zero fill
	output logic [vrst_pkg::OUT_W-1:0]          m_tdata,
	output logic                               m_tlast,
	// inside_res
	output logic                               m_tuser,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [vrst_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [vrst_pkg::COORD_W-1:0]   cfg_data
);
	import vrst_pkg::*;

	vrst_cmd_t  cmd;
	vrst_stat_t stat;

	assign cfg_ready = 1'b1;

	vrst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

	vrst_dp #(
		.BINS_X (BINS_X),
		.BINS_Y (BINS_Y),
		.BINS_Z (BINS_Z)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_valid & cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_data    (s_tdata),
		.cmd        (cmd),
		.stat       (stat),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_data   (m_tdata),
		.out_inside (m_tuser),
		.out_last   (m_tlast)
	);

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for the voxel ray segment tracer.
`timescale 1ns / 1ps
module tb_top;
	import vrst_pkg::*;

	localparam int NBIN = 16;

	typedef struct {
		logic [IDX_W-1:0]   vx;
		logic [IDX_W-1:0]   vy;
		logic [IDX_W-1:0]   vz;
		logic [CHORD_W-1:0] len;
		logic               hit;
		logic               last;
	} chord_t;

	logic                 clk = 0;
	logic                 arst_n = 0;
	logic                 s_tvalid = 0;
	logic                 s_tready;
	logic [IN_W-1:0]      s_tdata = '0;
	logic                 m_tvalid;
	logic                 m_tready = 0;
	logic [OUT_W-1:0]     m_tdata;
	logic                 m_tlast;
	logic                 m_tuser;
	logic                 cfg_valid = 0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [COORD_W-1:0]   cfg_data = '0;

	logic [IN_W-1:0] seg_q[$];
	chord_t          chord_q[$];
	longint          org[3];
	longint          binw[3];
	int              errors = 0;
	bit              calm = 0;
	bit              seg_taken = 0;

	voxel_ray_segment_tracer u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tlast(m_tlast), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	function automatic longint sx24(logic [COORD_W-1:0] v);
		return longint'(signed'(v));
	endfunction

	function automatic longint floor_div(longint d, longint b);
		if (d >= 0)
			return d / b;
		return -((-d + b - 1) / b);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, bitv;
		r = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv >>= 2;
		while (bitv != 0) begin
			if (v >= r + bitv) begin
				v -= r + bitv;
				r = (r >> 1) + bitv;
			end else begin
				r >>= 1;
			end
			bitv >>= 2;
		end
		return r;
	endfunction

	function automatic bit in_grid(longint ix[3]);
		for (int a = 0; a < 3; a++)
			if (ix[a] < 0 || ix[a] >= NBIN)
				return 0;
		return 1;
	endfunction

	function automatic chord_t make_chord(longint ix[3], longint unsigned c, bit ins);
		chord_t r;
		r.vx = ins ? ix[0][3:0] : '0;
		r.vy = ins ? ix[1][3:0] : '0;
		r.vz = ins ? ix[2][3:0] : '0;
		r.len = (c > 64'h1FFFFFF) ? 25'h1FFFFFF : c[24:0];
		r.hit = ins;
		r.last = 0;
		return r;
	endfunction

	// Walk boundary crossings in order of the crossing parameter and queue the chords.
	function automatic void trace_segment(logic [IN_W-1:0] d);
		longint s[3], e[3], ix[3], bn[3], bs[3], dr[3], dd, from, to, lo, hi, num;
		longint unsigned ad[3], an[3], sq, len, told, t;
		bit act[3];
		int best;
		chord_t res[$];
		sq = 0;
		told = 0;
		for (int a = 0; a < 3; a++) begin
			s[a] = sx24(d[a*COORD_W +: COORD_W]);
			e[a] = sx24(d[(a+3)*COORD_W +: COORD_W]);
			dd = e[a] - s[a];
			sq += longint'(dd * dd);
			ad[a] = dd < 0 ? -dd : dd;
			from = floor_div(s[a] - org[a], binw[a]);
			to = floor_div(e[a] - org[a], binw[a]);
			ix[a] = from;
			act[a] = 0;
			dr[a] = 0;
			bn[a] = 0;
			bs[a] = 0;
			if (dd > 0) begin
				lo = from + 1 > 0 ? from + 1 : 0;
				hi = to < NBIN ? to : NBIN;
				dr[a] = 1;
				bn[a] = lo;
				bs[a] = hi;
				act[a] = lo <= hi;
			end else if (dd < 0) begin
				hi = from < NBIN ? from : NBIN;
				lo = to + 1 > 0 ? to + 1 : 0;
				dr[a] = -1;
				bn[a] = hi;
				bs[a] = lo;
				act[a] = lo <= hi;
			end
		end
		len = int_sqrt(sq);
		forever begin
			best = -1;
			for (int a = 0; a < 3; a++) begin
				if (act[a]) begin
					num = org[a] + bn[a] * binw[a] - s[a];
					an[a] = num < 0 ? -num : num;
					if (an[a] > ad[a])
						an[a] = ad[a];
					if (best < 0 || an[a] * ad[best] < an[best] * ad[a])
						best = a;
				end
			end
			if (best < 0)
				break;
			t = (an[best] << 32) / ad[best];
			if (t > (64'd1 << 32))
				t = 64'd1 << 32;
			if (t < told)
				t = told;
			if (in_grid(ix) && res.size() < MAX_RES)
				res = {res, make_chord(ix, ((t - told) * len + (64'd1 << 31)) >> 32, 1)};
			told = t;
			ix[best] = dr[best] > 0 ? bn[best] : bn[best] - 1;
			if (bn[best] == bs[best])
				act[best] = 0;
			else
				bn[best] += dr[best];
		end
		if (in_grid(ix) && res.size() < MAX_RES)
			res = {res, make_chord(ix,
				(((64'd1 << 32) - told) * len + (64'd1 << 31)) >> 32, 1)};
		if (res.size() == 0)
			res = {res, make_chord(ix, 0, 0)};
		res[res.size()-1].last = 1;
		chord_q = {chord_q, res};
	endfunction

	// segment input: accept at posedge, drive at negedge
	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			trace_segment(s_tdata);
			seg_taken = 1;
		end
	end

	always @(negedge clk) begin
		if (!s_tvalid || seg_taken) begin
			if (seg_q.size() != 0 && (calm || $urandom_range(0, 99) >= 16)) begin
				s_tvalid <= 1;
				s_tdata <= seg_q.pop_front();
			end else begin
				s_tvalid <= 0;
			end
		end
		seg_taken = 0;
		m_tready <= calm || $urandom_range(0, 99) >= 16;
	end

	always @(posedge clk) begin
		chord_t x;
		if (m_tvalid && m_tready) begin
			if (chord_q.size() == 0) begin
				$error("unexpected chord transfer: tdata %h", m_tdata);
				errors++;
			end else begin
				x = chord_q.pop_front();
				if (m_tdata[3:0] !== x.vx) begin
					$error("voxel_x expected %0d got %0d", x.vx, m_tdata[3:0]);
					errors++;
				end
				if (m_tdata[7:4] !== x.vy) begin
					$error("voxel_y expected %0d got %0d", x.vy, m_tdata[7:4]);
					errors++;
				end
				if (m_tdata[11:8] !== x.vz) begin
					$error("voxel_z expected %0d got %0d", x.vz, m_tdata[11:8]);
					errors++;
				end
				if (m_tdata[36:12] !== x.len) begin
					$error("chord_length expected %0d got %0d", x.len, m_tdata[36:12]);
					errors++;
				end
				if (m_tuser !== x.hit) begin
					$error("inside_res expected %0d got %0d", x.hit, m_tuser);
					errors++;
				end
				if (m_tlast !== x.last) begin
					$error("last expected %0d got %0d", x.last, m_tlast);
					errors++;
				end
			end
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx < REG_BIN_X)
			org[idx] = sx24(val);
		else
			binw[idx - REG_BIN_X] = val[15:0] == 0 ? 1 : longint'(val[15:0]);
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	task automatic add_seg(int ax, int ay, int az, int bx, int by, int bz);
		logic [IN_W-1:0] v;
		v = {bz[23:0], by[23:0], bx[23:0], az[23:0], ay[23:0], ax[23:0]};
		seg_q = {seg_q, v};
	endtask

	// mostly near the grid, sometimes anywhere in range
	function automatic int pick_coord(int a);
		longint v;
		if ($urandom_range(0, 3) == 0)
			return int'($urandom());
		v = org[a] + longint'($urandom_range(0, 20)) * binw[a] - 2 * binw[a]
			+ longint'($urandom_range(0, 255)) - 128;
		if (v > 8388607)
			v = 8388607;
		if (v < -8388608)
			v = -8388608;
		return int'(v);
	endfunction

	task automatic add_random(int n);
		repeat (n)
			add_seg(pick_coord(0), pick_coord(1), pick_coord(2),
				pick_coord(0), pick_coord(1), pick_coord(2));
	endtask

	task automatic drain();
		while (seg_q.size() != 0 || s_tvalid || chord_q.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	initial begin
		for (int a = 0; a < 3; a++) begin
			org[a] = 0;
			binw[a] = 256;
		end
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		// reset grid: 0..4096 on every axis
		add_seg(100, 100, 100, 200, 200, 200);
		add_seg(1000, 1000, 1000, 1000, 1000, 1000);
		add_seg(-5, -5, -5, -5, -5, -5);
		add_seg(-256, 128, 128, 4352, 128, 128);
		add_seg(0, 0, 0, 4096, 4096, 4096);
		add_seg(4095, 4095, 4095, -1, -1, -1);
		add_seg(-1000, -1000, -1000, -500, 5000, -200);
		add_seg(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607);
		add_seg(8388607, -8388608, 0, -8388608, 8388607, 4000);
		add_seg(500, 4000, 300, 900, -300, 3000);
		add_seg(256, 512, 768, 1024, 1024, 1024);
		add_seg(1000, 2000, -100, 1000, 2000, 5000);
		add_random(50);
		drain();

		// extreme settings, no idling on either side
		calm = 1;
		write_reg(REG_ORIGIN_X, 24'h800000);
		write_reg(REG_ORIGIN_Y, 24'h7FFFFF);
		write_reg(REG_ORIGIN_Z, 24'h000000);
		write_reg(REG_BIN_X, 24'h00FFFF);
		write_reg(REG_BIN_Y, 24'h000001);
		write_reg(REG_BIN_Z, 24'h000000);
		add_seg(-8388608, 8388600, 0, 8388607, 8388607, 20);
		add_seg(0, 8388607, 5, -8388608, 8388590, -3);
		add_random(45);
		drain();

		calm = 0;
		write_reg(REG_ORIGIN_X, 24'($urandom_range(0, 8000)) - 24'd4000);
		write_reg(REG_ORIGIN_Y, 24'($urandom_range(0, 8000)) - 24'd4000);
		write_reg(REG_ORIGIN_Z, 24'($urandom_range(0, 8000)) - 24'd4000);
		write_reg(REG_BIN_X, 24'($urandom_range(16, 1024)));
		write_reg(REG_BIN_Y, 24'($urandom_range(16, 1024)));
		write_reg(REG_BIN_Z, 24'($urandom_range(16, 1024)));
		add_random(60);
		drain();

		if (errors == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

	initial begin
		#20ms;
		$display("tb_top: FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/vrst_pkg.sv
hw/rtl/vrst_div.sv
hw/rtl/vrst_sqrt.sv
hw/rtl/vrst_dp.sv
hw/rtl/vrst_ctrl.sv
hw/rtl/voxel_ray_segment_tracer.sv
test/tb_top.sv
